[sv/byterun1_rle_decoder_defines.svh]
// ----------------------------------------------------------------------------
// ByteRun1 decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTERUN1_RLE_DECODER_DEFINES_SVH
`define BYTERUN1_RLE_DECODER_DEFINES_SVH

// The expression holds at every clock edge out of reset.
`define BR1_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds at the next clock edge.
`define BR1_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/br1rle_pkg.sv]
// ----------------------------------------------------------------------------
// ByteRun1 decoder package
// Widths, register indexes and the queue entry shared by the decoder modules.
// ----------------------------------------------------------------------------
package br1rle_pkg;

	localparam int PIX_W    = 8;
	localparam int REP_W    = 8;
	localparam int CFG_W    = 12;
	localparam int ROWPIX_W = 13;
	localparam int CFG_IDX_W = 1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [PIX_W-1:0] NOP_CODE = 8'h80;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_TOTAL = 1'b1;

	localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 12'd320;
	localparam logic [CFG_W-1:0] ROW_TOTAL_RST = 12'd200;

	// One decoded pixel request handed from the front to the back.
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [REP_W-1:0] rep;
		logic             last;
	} entry_t;

endpackage

[sv/br1rle_front.sv]
// ----------------------------------------------------------------------------
// ByteRun1 decoder front end
// Parses control and data bytes and pushes one entry per data byte.
// ----------------------------------------------------------------------------
module br1rle_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [br1rle_pkg::PIX_W-1:0] code_byte,
	input  logic                       q_full,
	output logic                       push,
	output br1rle_pkg::entry_t         push_entry
);
	import br1rle_pkg::*;

	`include "byterun1_rle_decoder_defines.svh"

	typedef enum logic [2:0] {
		PH_CTRL = 3'b001,
		PH_RUN  = 3'b010,
		PH_LIT  = 3'b100
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [REP_W-1:0]  left_q, left_d;
	logic [REP_W-1:0]  left_dec;
	logic              accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign left_dec = left_q - REP_W'(1);

	always_comb begin
		phase_d          = phase_q;
		left_d           = left_q;
		push             = 1'b0;
		push_entry.pixel = code_byte;
		push_entry.rep   = left_q;
		push_entry.last  = 1'b1;
		case (phase_q)
			PH_RUN: begin
				push    = accept;
				phase_d = PH_CTRL;
				left_d  = '0;
			end
			PH_LIT: begin
				push            = accept;
				push_entry.rep  = REP_W'(1);
				push_entry.last = (left_dec == '0);
				left_d          = left_dec;
				if (left_dec == '0) begin
					phase_d = PH_CTRL;
				end
			end
			default: begin
				// Run length is 257 minus the code; literal count is code plus one.
				if (code_byte > NOP_CODE) begin
					phase_d = PH_RUN;
					left_d  = (code_byte ^ 8'hff) + REP_W'(2);
				end else if (code_byte < NOP_CODE) begin
					phase_d = PH_LIT;
					left_d  = code_byte + REP_W'(1);
				end else begin
					phase_d = PH_CTRL;
					left_d  = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CTRL;
			left_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

	`BR1_ASSERT(a_lit_left_nonzero, (phase_q != PH_LIT) || (left_q != '0), "literal count empty")

endmodule

[sv/br1rle_queue.sv]
// ----------------------------------------------------------------------------
// ByteRun1 decoder entry queue
// Small register FIFO that decouples byte parsing from row accounting.
// ----------------------------------------------------------------------------
module br1rle_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  br1rle_pkg::entry_t push_entry,
	output logic               full,
	output logic               q_valid,
	input  logic               pop,
	output br1rle_pkg::entry_t head
);
	import br1rle_pkg::*;

	`include "byterun1_rle_decoder_defines.svh"

	entry_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	`BR1_ASSERT(a_q_no_overflow, !(push && full && !pop), "push into full queue")
	`BR1_ASSERT(a_q_no_underflow, !(pop && !q_valid), "pop from empty queue")

endmodule

[sv/br1rle_back.sv]
// ----------------------------------------------------------------------------
// ByteRun1 decoder back end
// Counts pixels and rows, flags row and image ends, and holds the output.
// ----------------------------------------------------------------------------
module br1rle_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [br1rle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [br1rle_pkg::CFG_W-1:0]   cfg_data,
	input  logic                           q_valid,
	input  br1rle_pkg::entry_t             head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [br1rle_pkg::PIX_W-1:0]   pixel,
	output logic [br1rle_pkg::REP_W-1:0]   repeat_res,
	output logic                           row_end,
	output logic                           image_end
);
	import br1rle_pkg::*;

	`include "byterun1_rle_decoder_defines.svh"

	logic [CFG_W-1:0]    row_width_q, row_total_q;
	logic [ROWPIX_W-1:0] row_pixels_q, pix_sum, rows_inc;
	logic [CFG_W-1:0]    rows_done_q;
	logic                hit_row, hit_image;
	logic                out_valid_q, row_end_q, image_end_q;
	logic [PIX_W-1:0]    pixel_q;
	logic [REP_W-1:0]    rep_q;

	assign pop = q_valid && (!out_valid_q || !out_stall);

	assign pix_sum   = row_pixels_q + ROWPIX_W'(head.rep);
	assign hit_row   = head.last && (pix_sum >= ROWPIX_W'(row_width_q));
	assign rows_inc  = ROWPIX_W'(rows_done_q) + ROWPIX_W'(1);
	assign hit_image = hit_row && (rows_inc >= ROWPIX_W'(row_total_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RST;
			row_total_q <= ROW_TOTAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_WIDTH: row_width_q <= cfg_data;
				REG_ROW_TOTAL: row_total_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pixels_q <= '0;
			rows_done_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				row_pixels_q <= hit_row ? '0 : pix_sum;
				if (hit_row) begin
					rows_done_q <= hit_image ? '0 : rows_inc[CFG_W-1:0];
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pixel_q     <= head.pixel;
			rep_q       <= head.rep;
			row_end_q   <= hit_row;
			image_end_q <= hit_image;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel      = pixel_q;
	assign repeat_res = rep_q;
	assign row_end    = row_end_q;
	assign image_end  = image_end_q;

	`BR1_ASSERT(a_image_has_row, !out_valid_q || !image_end_q || row_end_q, "image end without row end")
	`BR1_ASSERT_NEXT(a_row_clears, pop && hit_row, row_pixels_q == '0, "row count not cleared")

endmodule

[sv/byterun1_rle_decoder.sv]
// ----------------------------------------------------------------------------
// ByteRun1 run-length decoder
// Decodes a PackBits byte stream into pixel/repeat requests with row and
// image end flags.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  input     in         in_valid / in_stall   code_byte
//  output    out        out_valid / out_stall pixel, repeat_res, row_end, image_end
//  config    in         cfg_we                cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; an accepted data byte is
// written into the entry queue and then, once the output register can take it,
// loaded into the output register, from which its request is offered.
// Control bytes and the no-op code produce no output request.
// Reset restores row_width 320, row_total 200 and clears all counters.
// A stalled output fills the two-entry queue, after which in_stall rises.
// ----------------------------------------------------------------------------
module byterun1_rle_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [br1rle_pkg::PIX_W-1:0]     code_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [br1rle_pkg::PIX_W-1:0]     pixel,
	output logic [br1rle_pkg::REP_W-1:0]     repeat_res,
	output logic                             row_end,
	output logic                             image_end,
	input  logic                             cfg_we,
	input  logic [br1rle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [br1rle_pkg::CFG_W-1:0]     cfg_data
);
	import br1rle_pkg::*;

	logic   q_full, push, pop, q_valid;
	entry_t push_entry, head;

	br1rle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_byte  (code_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	br1rle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.q_valid    (q_valid),
		.pop        (pop),
		.head       (head)
	);

	br1rle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_valid    (q_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel      (pixel),
		.repeat_res (repeat_res),
		.row_end    (row_end),
		.image_end  (image_end)
	);

endmodule
